FILE: rtl/core/evad_pkg.sv
package evad_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SQUARE_W = 32;
  localparam int SUM_W    = 43;
  localparam int LEN_W    = 13;
  localparam int THR_W    = 15;
  localparam int CFG_W    = 24;
  localparam int RMS_W    = 15;
  localparam int REG_IDX_W = 3;

  // long division over the frame energy, then a bit-pair square root (one root bit per step)
  localparam int WORK_W    = 44;
  localparam int ROOT_W    = 22;
  localparam int REM_W     = 24;
  localparam int SUB_W     = 26;
  localparam int STEP_W    = 6;
  localparam int DIV_STEPS = 43;
  localparam int SQRT_STEPS = 22;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_LENGTH   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SPEECH_THRESH  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SILENCE_THRESH = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SILENCE_END    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MIN_SPEECH     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DURATION   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RECORD_LIMIT   = 3'd6;

  localparam logic [LEN_W-1:0] RST_FRAME_LENGTH   = 13'd512;
  localparam logic [THR_W-1:0] RST_SPEECH_THRESH  = 15'd500;
  localparam logic [THR_W-1:0] RST_SILENCE_THRESH = 15'd300;
  localparam logic [CFG_W-1:0] RST_SILENCE_END    = 24'd16000;
  localparam logic [CFG_W-1:0] RST_MIN_SPEECH     = 24'd8000;
  localparam logic [CFG_W-1:0] RST_MAX_DURATION   = 24'd160000;
  localparam logic [CFG_W-1:0] RST_RECORD_LIMIT   = 24'd160000;

  localparam logic [RMS_W-1:0] RMS_MAX = 15'h7fff;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_SPEECH_START,
    EV_END_SILENCE,
    EV_END_DURATION
  } vad_event_t;

endpackage

FILE: rtl/core/energy_voice_activity_detector_unit.sv
// a sample that does not close a frame is taken in idle, then squared and accumulated
// a frame-closing sample then runs the divide and the square root before decide raises out_valid
// a new sample is taken only back in idle, once the last one is through; the pace is set by the
// shared subtractor that runs the 43-step divide and the 22-step square root; a stalled
// result beat holds the decide step and the input with it
// reset (rst_n low, synchronous): registers to defaults, listening, energy and counters cleared
module energy_voice_activity_detector_unit
  import evad_pkg::*;
#(
  parameter int MAX_FRAME  = 4096,
  parameter int COUNT_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // sample channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  // per-frame result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RMS_W-1:0]     out_rms_level,
  output logic                 out_recording,
  output logic [1:0]           out_frame_event,
  output logic                 out_frame_kept,
  output logic [CFG_W-1:0]     out_kept_samples
);

  // longest frame the 13-bit length register can ask for, capped by MAX_FRAME
  localparam int LEN_CLIP = (MAX_FRAME > 8191) ? 8191 : MAX_FRAME;
  localparam logic [LEN_W-1:0] LEN_CLIP_V = LEN_W'(LEN_CLIP);
  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ACCUM,
    S_DIV,
    S_SQRT,
    S_DECIDE
  } state_t;

  // configuration registers
  logic [LEN_W-1:0] frame_len_r;
  logic [THR_W-1:0] speech_thr_r;
  logic [THR_W-1:0] silence_thr_r;
  logic [CFG_W-1:0] silence_end_r;
  logic [CFG_W-1:0] min_speech_r;
  logic [CFG_W-1:0] max_dur_r;
  logic [CFG_W-1:0] rec_limit_r;

  // sequencer and datapath
  state_t state_r, state_nxt;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [SQUARE_W-1:0] square_r, square_nxt;
  logic [SUM_W-1:0]    sum_r;
  logic [LEN_W-1:0]    pos_r;
  logic [WORK_W-1:0]   work_r, work_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [STEP_W-1:0]   step_r;

  // utterance tracking
  logic                  rec_r;
  logic [CFG_W-1:0]      kept_r;
  logic [COUNT_BITS-1:0] since_start_r;
  logic [COUNT_BITS-1:0] since_speech_r;

  // output register
  logic              out_valid_r;
  logic [RMS_W-1:0]  out_rms_r;
  logic              out_rec_r;
  vad_event_t        out_event_r;
  logic              out_kept_r;
  logic [CFG_W-1:0]  out_kept_cnt_r;

  // effective frame length: zero acts as one, long values clip
  logic [LEN_W-1:0] len_eff;
  always_comb begin
    if (frame_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (frame_len_r > LEN_CLIP_V) begin
      len_eff = LEN_CLIP_V;
    end else begin
      len_eff = frame_len_r;
    end
  end

  // accumulate step
  logic [SUM_W-1:0] sum_add;
  logic [LEN_W-1:0] pos_inc;
  logic             frame_end;
  assign sum_add   = sum_r + SUM_W'(square_r);
  assign pos_inc   = pos_r + LEN_W'(1);
  assign frame_end = (pos_inc >= len_eff);

  logic signed [SQUARE_W-1:0] square_full;
  assign square_full = sample_r * sample_r;
  assign square_nxt  = $unsigned(square_full);

  // shared compare-subtract unit: divide steps and square-root steps take turns on it
  logic [SUB_W-1:0] sub_a, sub_b;
  logic [SUB_W:0]   sub_diff;
  logic             sub_ge;
  always_comb begin
    if (state_r == S_SQRT) begin
      sub_a = {rem_r, work_r[WORK_W-1 -: 2]};
      sub_b = {2'b00, root_r, 2'b01};
    end else begin
      // divide: shift the next dividend bit into the partial remainder
      sub_a = {{(SUB_W-LEN_W-1){1'b0}}, rem_r[LEN_W-1:0], work_r[SUM_W-1]};
      sub_b = {{(SUB_W-LEN_W){1'b0}}, len_eff};
    end
  end
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = ~sub_diff[SUB_W];

  always_comb begin
    work_nxt = work_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (state_r == S_SQRT) begin
      work_nxt = {work_r[WORK_W-3:0], 2'b00};
      rem_nxt  = sub_ge ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
      root_nxt = {root_r[ROOT_W-2:0], sub_ge};
    end else if (state_r == S_DIV) begin
      // quotient bits shift in where the dividend bits leave
      work_nxt = {1'b0, work_r[SUM_W-2:0], sub_ge};
      rem_nxt  = sub_ge ? {{(REM_W-LEN_W){1'b0}}, sub_diff[LEN_W-1:0]}
                        : {{(REM_W-LEN_W){1'b0}}, sub_a[LEN_W-1:0]};
    end
  end

  // frame decision
  logic [RMS_W-1:0]      rms_sat;
  logic [CFG_W:0]        kept_sum;
  logic                  keep_ok;
  logic [COUNT_BITS:0]   start_add, speech_add;
  logic [COUNT_BITS-1:0] start_sat, speech_sat, speech_upd;
  logic                  max_dur, silence_end, min_speech;

  assign rms_sat  = (root_r[ROOT_W-1:RMS_W] != '0) ? RMS_MAX : root_r[RMS_W-1:0];
  assign kept_sum = {1'b0, kept_r} + (CFG_W+1)'(len_eff);
  assign keep_ok  = (kept_sum < {1'b0, rec_limit_r});

  assign start_add  = {1'b0, since_start_r}  + (COUNT_BITS+1)'(len_eff);
  assign speech_add = {1'b0, since_speech_r} + (COUNT_BITS+1)'(len_eff);
  assign start_sat  = start_add[COUNT_BITS]  ? COUNT_MAX : start_add[COUNT_BITS-1:0];
  assign speech_sat = speech_add[COUNT_BITS] ? COUNT_MAX : speech_add[COUNT_BITS-1:0];
  // speech in the frame restarts the silence count
  assign speech_upd = (rms_sat > silence_thr_r) ? '0 : speech_sat;

  assign max_dur     = CMP_W'(start_sat)  >= CMP_W'(max_dur_r);
  assign silence_end = CMP_W'(speech_upd) >= CMP_W'(silence_end_r);
  assign min_speech  = CMP_W'(start_sat)  >= CMP_W'(min_speech_r);

  logic out_free;
  assign out_free = ~out_valid_r | ~out_stall;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_SQUARE;
      S_SQUARE: state_nxt = S_ACCUM;
      S_ACCUM:  state_nxt = frame_end ? S_DIV : S_IDLE;
      S_DIV:    if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = S_SQRT;
      S_SQRT:   if (step_r == STEP_W'(SQRT_STEPS - 1)) state_nxt = S_DECIDE;
      S_DECIDE: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      frame_len_r    <= RST_FRAME_LENGTH;
      speech_thr_r   <= RST_SPEECH_THRESH;
      silence_thr_r  <= RST_SILENCE_THRESH;
      silence_end_r  <= RST_SILENCE_END;
      min_speech_r   <= RST_MIN_SPEECH;
      max_dur_r      <= RST_MAX_DURATION;
      rec_limit_r    <= RST_RECORD_LIMIT;
      sum_r          <= '0;
      pos_r          <= '0;
      step_r         <= '0;
      rec_r          <= 1'b0;
      kept_r         <= '0;
      since_start_r  <= '0;
      since_speech_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_LENGTH:   frame_len_r   <= cfg_data[LEN_W-1:0];
          REG_SPEECH_THRESH:  speech_thr_r  <= cfg_data[THR_W-1:0];
          REG_SILENCE_THRESH: silence_thr_r <= cfg_data[THR_W-1:0];
          REG_SILENCE_END:    silence_end_r <= cfg_data;
          REG_MIN_SPEECH:     min_speech_r  <= cfg_data;
          REG_MAX_DURATION:   max_dur_r     <= cfg_data;
          REG_RECORD_LIMIT:   rec_limit_r   <= cfg_data;
          default: ;
        endcase
      end

      // a new result beat replaces the one leaving in the same cycle
      if (state_r == S_DECIDE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            sample_r <= in_sample;
          end
        end
        S_SQUARE: begin
          square_r <= square_nxt;
        end
        S_ACCUM: begin
          if (frame_end) begin
            sum_r  <= '0;
            pos_r  <= '0;
            work_r <= {1'b0, sum_add};
            rem_r  <= '0;
            root_r <= '0;
            step_r <= '0;
          end else begin
            sum_r <= sum_add;
            pos_r <= pos_inc;
          end
        end
        S_DIV: begin
          work_r <= work_nxt;
          rem_r  <= (step_r == STEP_W'(DIV_STEPS - 1)) ? '0 : rem_nxt;
          step_r <= (step_r == STEP_W'(DIV_STEPS - 1)) ? '0 : step_r + STEP_W'(1);
        end
        S_SQRT: begin
          work_r <= work_nxt;
          rem_r  <= rem_nxt;
          root_r <= root_nxt;
          step_r <= step_r + STEP_W'(1);
        end
        S_DECIDE: begin
          if (out_free) begin
            out_rms_r   <= rms_sat;
            if (!rec_r) begin
              if (rms_sat > speech_thr_r) begin
                // speech start: the opening frame is kept unconditionally
                rec_r          <= 1'b1;
                kept_r         <= CFG_W'(len_eff);
                since_start_r  <= '0;
                since_speech_r <= '0;
                out_rec_r      <= 1'b1;
                out_event_r    <= EV_SPEECH_START;
                out_kept_r     <= 1'b1;
                out_kept_cnt_r <= CFG_W'(len_eff);
              end else begin
                out_rec_r      <= 1'b0;
                out_event_r    <= EV_NONE;
                out_kept_r     <= 1'b0;
                out_kept_cnt_r <= kept_r;
              end
            end else begin
              since_start_r  <= start_sat;
              since_speech_r <= speech_upd;
              out_kept_r     <= keep_ok;
              if (keep_ok) begin
                kept_r         <= kept_sum[CFG_W-1:0];
                out_kept_cnt_r <= kept_sum[CFG_W-1:0];
              end else begin
                out_kept_cnt_r <= kept_r;
              end
              // duration wins when both end causes hold
              if (max_dur) begin
                rec_r       <= 1'b0;
                out_rec_r   <= 1'b0;
                out_event_r <= EV_END_DURATION;
              end else if (silence_end && min_speech) begin
                rec_r       <= 1'b0;
                out_rec_r   <= 1'b0;
                out_event_r <= EV_END_SILENCE;
              end else begin
                out_rec_r   <= 1'b1;
                out_event_r <= EV_NONE;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_rms_level    = out_rms_r;
  assign out_recording    = out_rec_r;
  assign out_frame_event  = out_event_r;
  assign out_frame_kept   = out_kept_r;
  assign out_kept_samples = out_kept_cnt_r;

`ifndef SYNTHESIS
  // a taken sample closes the door until the sequencer is back in idle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("sample taken while a previous one is still in work");

  // partial remainder of the divide always stays below the frame length
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r[LEN_W-1:0] < len_eff)
    else $error("divide remainder out of range");

  // step counter never runs past the divide length
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV || state_r == S_SQRT |-> step_r < STEP_W'(DIV_STEPS))
    else $error("iteration counter overrun");

  // speech start keeps its frame and enters recording
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_event == EV_SPEECH_START |-> out_recording && out_frame_kept)
    else $error("speech start without recording");

  // an end event always returns to listening
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_event == EV_END_SILENCE || out_frame_event == EV_END_DURATION)
      |-> !out_recording)
    else $error("end event while still recording");
`endif

endmodule
